// File: hdl/sbusd_pkg.sv
package sbusd_pkg;

  localparam int unsigned FRAME_LEN   = 25;
  localparam int unsigned NUM_CH      = 16;
  localparam int unsigned CH_BITS     = 11;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned SCALED_W    = 13;
  localparam int unsigned OFFSET_W    = 12;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0] FRAME_HEAD = 8'h0F;
  localparam logic [7:0] FRAME_TAIL = 8'h00;

  localparam logic [IDX_W-1:0] FIRST_DATA_BYTE = IDX_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  localparam logic [7:0]          GAP_RESET    = 8'd3;
  localparam logic [15:0]         HOLD_RESET   = 16'd2000;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd880;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0]    index;
    logic [CH_BITS-1:0] raw;
    logic               last;
  } chan_t;

endpackage

// File: hdl/sbusd_out_reg.sv
module sbusd_out_reg
  import sbusd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  chan_t               chan,
  input  logic [OFFSET_W-1:0] offset,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CH_W-1:0]     out_channel_index,
  output logic [CH_BITS-1:0]  out_channel_raw,
  output logic [SCALED_W-1:0] out_channel_scaled,
  output logic                out_frame_last
);

  logic                valid_r;
  logic [CH_W-1:0]     index_r;
  logic [CH_BITS-1:0]  raw_r;
  logic [SCALED_W-1:0] scaled_r;
  logic                last_r;
  logic [CH_BITS+3:0]  times5;
  logic [SCALED_W-1:0] scaled_nxt;

  // Scaling by 0.625 is raw * 5 / 8, floored.
  assign times5     = {3'b000, chan.raw} + {1'b0, chan.raw, 2'b00};
  assign scaled_nxt = SCALED_W'(times5[CH_BITS+3:3]) + SCALED_W'(offset);
  assign slot_free  = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      index_r  <= chan.index;
      raw_r    <= chan.raw;
      scaled_r <= scaled_nxt;
      last_r   <= chan.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_channel_index  = index_r;
  assign out_channel_raw    = raw_r;
  assign out_channel_scaled = scaled_r;
  assign out_frame_last     = last_r;

endmodule

// File: hdl/sbus_frame_decoder.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_rx_byte, in_now_ms
// out     | output    | out_valid/out_ready| out_channel_index, raw, scaled, frame_last
// cfg     | input     | cfg_we, no wait    | cfg_index, cfg_wdata
// A byte accepted while idle is written to the 25-entry frame memory unless in_now_ms
// is below the hold value. After a good frame the sequencer reads bytes 1 to 22 one at a
// time and emits sixteen channel items, reading each byte through the FETCH and LOAD
// states and emitting each channel from the EMIT state. The frame memory has a single read
// port; in_ready stays low until the sequencer is back in idle.
// Reset is synchronous and clears control state; the frame memory is not cleared.
// A stalled output holds the sequencer in its emit step without losing an item.
module sbus_frame_decoder
  import sbusd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic [31:0]          in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_channel_index,
  output logic [CH_BITS-1:0]   out_channel_raw,
  output logic [SCALED_W-1:0]  out_channel_scaled,
  output logic                 out_frame_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ACC_W  = CH_BITS - 1 + BYTE_BITS;
  localparam int unsigned NBIT_W = 5;

  logic [7:0] frame_mem [FRAME_LEN];

  state_t               state_r, state_nxt;
  logic [7:0]           gap_r;
  logic [15:0]          hold_r;
  logic [OFFSET_W-1:0]  offset_r;
  logic [31:0]          last_ms_r, last_ms_nxt;
  logic [IDX_W-1:0]     count_r, count_nxt;
  logic                 head_ok_r, head_ok_nxt;
  logic [IDX_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic [7:0]           rd_data_r;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [NBIT_W-1:0]    nbits_r, nbits_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     wr_idx;
  logic [31:0]          delta;
  logic                 gap_hit;
  logic                 held;
  logic [NBIT_W-1:0]    nbits_plus;
  logic [NBIT_W-1:0]    nbits_minus;
  logic                 emit;
  logic                 slot_free;
  chan_t                chan;

  assign delta       = in_now_ms - last_ms_r;
  assign gap_hit     = delta > {24'd0, gap_r};
  assign held        = in_now_ms < {16'd0, hold_r};
  assign wr_idx      = gap_hit ? '0 : count_r;
  assign nbits_plus  = nbits_r + NBIT_W'(BYTE_BITS);
  assign nbits_minus = nbits_r - NBIT_W'(CH_BITS);

  assign chan.index = ch_r;
  assign chan.raw   = acc_r[CH_BITS-1:0];
  assign chan.last  = (ch_r == CH_W'(NUM_CH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r    <= GAP_RESET;
      hold_r   <= HOLD_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAP:    gap_r    <= cfg_wdata[7:0];
        CFG_HOLD:   hold_r   <= cfg_wdata[15:0];
        CFG_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        default:    ;
      endcase
    end
  end

  // Writes happen only while idle and the read data is used only while
  // unpacking, so a write never meets a read whose data is used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_idx] <= in_rx_byte;
    end
    rd_data_r <= frame_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      last_ms_r <= '0;
      count_r   <= '0;
      head_ok_r <= 1'b0;
      rd_addr_r <= '0;
      acc_r     <= '0;
      nbits_r   <= '0;
      ch_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      last_ms_r <= last_ms_nxt;
      count_r   <= count_nxt;
      head_ok_r <= head_ok_nxt;
      rd_addr_r <= rd_addr_nxt;
      acc_r     <= acc_nxt;
      nbits_r   <= nbits_nxt;
      ch_r      <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    last_ms_nxt = last_ms_r;
    count_nxt   = count_r;
    head_ok_nxt = head_ok_r;
    rd_addr_nxt = rd_addr_r;
    acc_nxt     = acc_r;
    nbits_nxt   = nbits_r;
    ch_nxt      = ch_r;
    mem_we      = 1'b0;
    emit        = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !held) begin
          last_ms_nxt = in_now_ms;
          mem_we      = 1'b1;
          if (wr_idx == '0) begin
            head_ok_nxt = (in_rx_byte == FRAME_HEAD);
          end
          if (wr_idx == IDX_W'(FRAME_LEN - 1)) begin
            count_nxt = '0;
            if (head_ok_r && in_rx_byte == FRAME_TAIL) begin
              state_nxt   = ST_FETCH;
              rd_addr_nxt = FIRST_DATA_BYTE;
              acc_nxt     = '0;
              nbits_nxt   = '0;
              ch_nxt      = '0;
            end
          end else begin
            count_nxt = wr_idx + IDX_W'(1);
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        acc_nxt     = acc_r | (ACC_W'(rd_data_r) << nbits_r);
        nbits_nxt   = nbits_plus;
        rd_addr_nxt = rd_addr_r + IDX_W'(1);
        state_nxt   = (nbits_plus >= NBIT_W'(CH_BITS)) ? ST_EMIT : ST_FETCH;
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          acc_nxt   = acc_r >> CH_BITS;
          nbits_nxt = nbits_minus;
          ch_nxt    = ch_r + CH_W'(1);
          if (chan.last) begin
            state_nxt = ST_IDLE;
          end else if (nbits_minus >= NBIT_W'(CH_BITS)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  sbusd_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (emit),
    .chan               (chan),
    .offset             (offset_r),
    .slot_free          (slot_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_index  (out_channel_index),
    .out_channel_raw    (out_channel_raw),
    .out_channel_scaled (out_channel_scaled),
    .out_frame_last     (out_frame_last)
  );

endmodule
